### design/cosine_sum_window_applier_core_assert.svh
// Assertion macros for the checker of the cosine-sum window applier.
`ifndef COSINE_SUM_WINDOW_APPLIER_CORE_ASSERT_SVH
`define COSINE_SUM_WINDOW_APPLIER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and switched off during reset.
`define CSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off during reset.
`define CSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/csw_pkg.sv
// Types, codes, window weights and cosine table maths for the window applier.
package csw_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_WINDOW_TYPE  = 3'd0;
  localparam logic [2:0] REG_FRAME_LENGTH = 3'd1;
  localparam logic [2:0] REG_PHASE_STEP   = 3'd2;
  localparam logic [2:0] REG_TUKEY_RAMP   = 3'd3;
  localparam logic [2:0] REG_TUKEY_STEP   = 3'd4;

  // Window type codes.
  localparam logic [2:0] WIN_RECT     = 3'd0;
  localparam logic [2:0] WIN_HANN     = 3'd1;
  localparam logic [2:0] WIN_HAMMING  = 3'd2;
  localparam logic [2:0] WIN_BLACKMAN = 3'd3;
  localparam logic [2:0] WIN_BLK_HARR = 3'd4;
  localparam logic [2:0] WIN_FLAT_TOP = 3'd5;
  localparam logic [2:0] WIN_NUTTALL  = 3'd6;
  localparam logic [2:0] WIN_TUKEY    = 3'd7;

  // Unity coefficient in Q2.16.
  localparam logic signed [17:0] COEF_ONE = 18'sd65536;

  // Pi over two in Q30.
  localparam longint PIH_Q30 = 64'sd1686629713;

  // Side information that travels with every item.
  typedef struct packed {
    logic err;   // index at or beyond the frame length
    logic fend;  // last index of the frame
    logic tky;   // Tukey taper: coefficient from the single cosine
    logic flat;  // Tukey outside the tapers: unity coefficient
  } ctl_t;

  typedef struct packed {
    logic [16:0]      a0;
    logic [3:0][15:0] ak;  // ak[0] weighs the first harmonic
  } win_wts_t;

  function automatic win_wts_t win_weights(input logic [2:0] wt);
    win_wts_t w;
    w.a0 = 17'd65536;
    w.ak = '0;
    case (wt)
      WIN_RECT: begin
        w.a0 = 17'd65536;
      end
      WIN_HANN: begin
        w.a0 = 17'd32768;
        w.ak[0] = 16'd32768;
      end
      WIN_HAMMING: begin
        w.a0 = 17'd35389;
        w.ak[0] = 16'd30147;
      end
      WIN_BLACKMAN: begin
        w.a0 = 17'd27525;
        w.ak[0] = 16'd32768;
        w.ak[1] = 16'd5243;
      end
      WIN_BLK_HARR: begin
        w.a0 = 17'd23511;
        w.ak[0] = 16'd32001;
        w.ak[1] = 16'd9259;
        w.ak[2] = 16'd765;
      end
      WIN_FLAT_TOP: begin
        w.a0 = 17'd14128;
        w.ak[0] = 16'd27304;
        w.ak[1] = 16'd18171;
        w.ak[2] = 16'd5477;
        w.ak[3] = 16'd455;
      end
      WIN_NUTTALL: begin
        w.a0 = 17'd23828;
        w.ak[0] = 16'd32059;
        w.ak[1] = 16'd8952;
        w.ak[2] = 16'd697;
      end
      WIN_TUKEY: begin
        w.a0 = 17'd65536;
      end
      default: begin
        w.a0 = 17'd65536;
      end
    endcase
    return w;
  endfunction

  // Quarter-wave cosine entry in Q16 from an angle x in Q30, by a
  // nine-term Taylor series. Only ever evaluated at elaboration.
  function automatic logic [16:0] cos_entry(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = 64'sd1 <<< 30;
    sum  = term;
    term = ((term * x2) >>> 30) / 2;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 12;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 30;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 56;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 90;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 132;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 182;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 240;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd8192) >>> 14;
    if (sum > 64'sd65536) begin
      sum = 64'sd65536;
    end
    return 17'(sum);
  endfunction

endpackage

### design/csw_ram.sv
// Generic RAM with one write port and two registered read ports.
module csw_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1025,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/csw_phase.sv
// Front stages: index checks, Tukey taper distance and the phase multiply.
module csw_phase import csw_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] sample_i,
  input  logic [11:0]        index_i,
  input  logic [2:0]         window_type_i,
  input  logic [12:0]        frame_length_i,
  input  logic [31:0]        phase_step_i,
  input  logic [11:0]        tukey_ramp_i,
  input  logic [31:0]        tukey_step_i,
  output logic               valid_o,
  output logic signed [15:0] sample_o,
  output logic [31:0]        phase_o,
  output ctl_t               ctl_o
);

  logic               v1_q, v2_q, v3_q;
  logic signed [15:0] s1_q, s2_q, s3_q;
  logic [11:0]        n1_q, n2_q;
  logic [11:0]        m2_q, m2_d;
  ctl_t               ctl2_q, ctl2_d, ctl3_q;
  logic [31:0]        ph3_q, ph3_d;

  logic [12:0] len;
  logic [12:0] dist_b;
  logic        err, a_lt, b_lt;
  logic [11:0] mul_n;
  logic [31:0] mul_s;
  logic [43:0] mul_p;

  // Effective frame length is the configured length clamped to the maximum.
  assign len = (32'(frame_length_i) < MAX_LENGTH) ? frame_length_i : 13'(MAX_LENGTH);

  always_comb begin
    err    = {1'b0, n1_q} >= len;
    dist_b = len - 13'd1 - {1'b0, n1_q};
    a_lt   = n1_q < tukey_ramp_i;
    b_lt   = dist_b < {1'b0, tukey_ramp_i};
    // With both ends inside a taper the larger distance wins.
    if (a_lt && b_lt) begin
      m2_d = (n1_q > dist_b[11:0]) ? n1_q : dist_b[11:0];
    end else if (a_lt) begin
      m2_d = n1_q;
    end else if (b_lt) begin
      m2_d = dist_b[11:0];
    end else begin
      m2_d = '0;
    end
    ctl2_d.err  = err;
    ctl2_d.fend = !err && ({1'b0, n1_q} == len - 13'd1);
    ctl2_d.tky  = (window_type_i == WIN_TUKEY) && (a_lt || b_lt);
    ctl2_d.flat = (window_type_i == WIN_TUKEY) && !(a_lt || b_lt);
  end

  always_comb begin
    mul_n = ctl2_q.tky ? m2_q : n2_q;
    mul_s = ctl2_q.tky ? tukey_step_i : phase_step_i;
    mul_p = 44'(mul_n) * 44'(mul_s);
    // The taper phase is shifted by half a turn.
    ph3_d = mul_p[31:0] ^ {ctl2_q.tky, 31'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= sample_i;
    n1_q   <= index_i;
    s2_q   <= s1_q;
    n2_q   <= n1_q;
    m2_q   <= m2_d;
    ctl2_q <= ctl2_d;
    s3_q   <= s2_q;
    ph3_q  <= ph3_d;
    ctl3_q <= ctl2_q;
  end

  assign valid_o  = v3_q;
  assign sample_o = s3_q;
  assign phase_o  = ph3_q;
  assign ctl_o    = ctl3_q;

endmodule

### design/csw_lookup.sv
// Four cosine lookups per item from a quarter-wave table held in two RAMs.
module csw_lookup import csw_pkg::*; #(
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] sample_i,
  input  logic [31:0]        phase_i,
  input  ctl_t               ctl_i,
  output logic               fill_done_o,
  output logic               valid_o,
  output logic signed [15:0] sample_o,
  output ctl_t               ctl_o,
  output logic [3:0][16:0]   mag_o,
  output logic [3:0]         neg_o
);

  localparam int unsigned RomDepth = COS_TABLE_DEPTH + 1;
  localparam int unsigned IdxW     = $clog2(RomDepth);
  localparam int unsigned ProdW    = 30 + IdxW;

  logic [16:0] rom_w [RomDepth];

  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    localparam longint X =
        (longint'(k) * PIH_Q30 + longint'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
    assign rom_w[k] = cos_entry(X);
  end

  // Table copy into both RAMs after reset, one entry per cycle.
  logic [IdxW-1:0] fill_cnt_q, fill_cnt_d;
  logic            fill_done_q, fill_done_d;

  always_comb begin
    fill_cnt_d  = fill_cnt_q;
    fill_done_d = fill_done_q;
    if (!fill_done_q) begin
      if (fill_cnt_q == IdxW'(COS_TABLE_DEPTH)) begin
        fill_done_d = 1'b1;
      end else begin
        fill_cnt_d = fill_cnt_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q  <= '0;
      fill_done_q <= 1'b0;
    end else begin
      fill_cnt_q  <= fill_cnt_d;
      fill_done_q <= fill_done_d;
    end
  end

  // Stage: harmonic phases, quadrant and scaled position in the quadrant.
  logic                  v4_q, v5_q;
  logic signed [15:0]    s4_q, s5_q;
  ctl_t                  ctl4_q, ctl5_q;
  logic [3:0][1:0]       quad_q;
  logic [3:0][ProdW-1:0] pos_q;
  logic [3:0]            neg_q;
  logic [3:0][31:0]      ph_k;
  logic [3:0][ProdW-1:0] pos_d;
  logic [3:0][ProdW-1:0] pos_rnd;
  logic [3:0][IdxW-1:0]  idx;
  logic [3:0][IdxW-1:0]  addr;
  logic [3:0]            neg_d;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    assign ph_k[g]    = 32'(phase_i * 32'(g + 1));
    assign pos_d[g]   = ProdW'(ph_k[g][29:0]) * ProdW'(COS_TABLE_DEPTH);
    assign pos_rnd[g] = pos_q[g] + ProdW'(32'h2000_0000);
    assign idx[g]     = pos_rnd[g][ProdW-1:30];
    // Odd quadrants run the table backwards; the middle two are negative.
    assign addr[g]    = quad_q[g][0] ? (IdxW'(COS_TABLE_DEPTH) - idx[g]) : idx[g];
    assign neg_d[g]   = quad_q[g][1] ^ quad_q[g][0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q   <= sample_i;
    ctl4_q <= ctl_i;
    for (int g = 0; g < 4; g++) begin
      quad_q[g] <= ph_k[g][31:30];
    end
    pos_q  <= pos_d;
    s5_q   <= s4_q;
    ctl5_q <= ctl4_q;
    neg_q  <= neg_d;
  end

  csw_ram #(
    .WIDTH (17),
    .DEPTH (RomDepth)
  ) u_ram_lo (
    .clk_i     (clk_i),
    .we_i      (!fill_done_q),
    .waddr_i   (fill_cnt_q),
    .wdata_i   (rom_w[fill_cnt_q]),
    .raddr_a_i (addr[0]),
    .raddr_b_i (addr[1]),
    .rdata_a_o (mag_o[0]),
    .rdata_b_o (mag_o[1])
  );

  csw_ram #(
    .WIDTH (17),
    .DEPTH (RomDepth)
  ) u_ram_hi (
    .clk_i     (clk_i),
    .we_i      (!fill_done_q),
    .waddr_i   (fill_cnt_q),
    .wdata_i   (rom_w[fill_cnt_q]),
    .raddr_a_i (addr[2]),
    .raddr_b_i (addr[3]),
    .rdata_a_o (mag_o[2]),
    .rdata_b_o (mag_o[3])
  );

  assign fill_done_o = fill_done_q;
  assign valid_o     = v5_q;
  assign sample_o    = s5_q;
  assign ctl_o       = ctl5_q;
  assign neg_o       = neg_q;

endmodule

### design/csw_mix.sv
// Weighted cosine sum and Tukey taper, giving the Q2.16 coefficient.
module csw_mix import csw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         window_type_i,
  input  logic               valid_i,
  input  logic signed [15:0] sample_i,
  input  ctl_t               ctl_i,
  input  logic [3:0][16:0]   mag_i,
  input  logic [3:0]         neg_i,
  output logic               valid_o,
  output logic signed [15:0] sample_o,
  output ctl_t               ctl_o,
  output logic signed [17:0] coef_o
);

  localparam int unsigned AccW = 38;

  win_wts_t w;
  assign w = win_weights(window_type_i);

  // Stage: one product per harmonic, plus the taper value.
  logic               v6_q, v7_q, v8_q;
  logic signed [15:0] s6_q, s7_q, s8_q;
  ctl_t               ctl6_q, ctl7_q, ctl8_q;
  logic [3:0][32:0]   prod_q, prod_d;
  logic [3:0]         sub_q, sub_d;
  logic [16:0]        tkc6_q, tkc7_q, tkc_d;
  logic [17:0]        tk_sum;

  for (genvar g = 0; g < 4; g++) begin : g_prod
    localparam bit OddHarm = (g % 2) == 0;
    assign prod_d[g] = 33'(w.ak[g]) * 33'(mag_i[g]);
    assign sub_d[g]  = neg_i[g] ^ OddHarm;
  end

  assign tk_sum = neg_i[0] ? (18'd65537 - 18'(mag_i[0])) : (18'd65537 + 18'(mag_i[0]));
  assign tkc_d  = tk_sum[17:1];

  // Stage: two partial sums.
  logic signed [3:0][AccW-1:0] term;
  logic signed [AccW-1:0]      base;
  logic signed [AccW-1:0]      sum_a_q, sum_a_d, sum_b_q, sum_b_d;

  for (genvar g = 0; g < 4; g++) begin : g_term
    assign term[g] = sub_q[g] ? -$signed(AccW'(prod_q[g])) : $signed(AccW'(prod_q[g]));
  end

  assign base    = $signed({5'b0, w.a0, 16'b0}) + AccW'(32'sd32768);
  assign sum_a_d = base + term[0] + term[1];
  assign sum_b_d = term[2] + term[3];

  // Stage: final sum, rounding to Q2.16, selection and clamp.
  logic signed [AccW-1:0]    acc;
  logic signed [AccW-17:0]   acc_sh;
  logic signed [17:0]        coef_d, coef8_q, clamped;

  always_comb begin
    acc    = sum_a_q + sum_b_q;
    acc_sh = acc[AccW-1:16];
    if (acc_sh > (AccW-16)'(131071)) begin
      clamped = 18'sd131071;
    end else if (acc_sh < -(AccW-16)'(131072)) begin
      clamped = -18'sd131072;
    end else begin
      clamped = acc_sh[17:0];
    end
    if (ctl7_q.err) begin
      coef_d = '0;
    end else if (ctl7_q.flat) begin
      coef_d = COEF_ONE;
    end else if (ctl7_q.tky) begin
      coef_d = $signed({1'b0, tkc7_q});
    end else begin
      coef_d = clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v6_q <= valid_i;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_q    <= sample_i;
    ctl6_q  <= ctl_i;
    prod_q  <= prod_d;
    sub_q   <= sub_d;
    tkc6_q  <= tkc_d;
    s7_q    <= s6_q;
    ctl7_q  <= ctl6_q;
    tkc7_q  <= tkc6_q;
    sum_a_q <= sum_a_d;
    sum_b_q <= sum_b_d;
    s8_q    <= s7_q;
    ctl8_q  <= ctl7_q;
    coef8_q <= coef_d;
  end

  assign valid_o  = v8_q;
  assign sample_o = s8_q;
  assign ctl_o    = ctl8_q;
  assign coef_o   = coef8_q;

endmodule

### design/csw_apply.sv
// Sample times coefficient, rounded and saturated, into the result registers.
module csw_apply import csw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] sample_i,
  input  ctl_t               ctl_i,
  input  logic signed [17:0] coef_i,
  output logic               done_o,
  output logic signed [15:0] windowed_sample_o,
  output logic signed [17:0] coefficient_o,
  output logic               frame_end_o,
  output logic               index_error_o
);

  logic               v9_q, done_q;
  logic signed [33:0] prod9_q, prod_d;
  logic signed [17:0] coef9_q, coef_q;
  ctl_t               ctl9_q;
  logic signed [34:0] rnd;
  logic signed [18:0] y;
  logic signed [15:0] y_d, y_q;
  logic               fend_q, err_q;

  assign prod_d = 34'(sample_i) * 34'(coef_i);

  always_comb begin
    rnd = 35'(prod9_q) + 35'sd32768;
    y   = rnd[34:16];
    if (ctl9_q.err) begin
      y_d = '0;
    end else if (y > 19'sd32767) begin
      y_d = 16'sd32767;
    end else if (y < -19'sd32768) begin
      y_d = -16'sd32768;
    end else begin
      y_d = y[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v9_q   <= valid_i;
      done_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod9_q <= prod_d;
    coef9_q <= coef_i;
    ctl9_q  <= ctl_i;
    y_q     <= y_d;
    coef_q  <= coef9_q;
    fend_q  <= ctl9_q.fend;
    err_q   <= ctl9_q.err;
  end

  assign done_o            = done_q;
  assign windowed_sample_o = y_q;
  assign coefficient_o     = coef_q;
  assign frame_end_o       = fend_q;
  assign index_error_o     = err_q;

endmodule

### design/cosine_sum_window_applier_core.sv
// done_o marks an item's result once it has passed the phase, lookup, mix and apply stages.
// Throughput: one item per cycle while busy_o is low; the result ports are plain registers, never stalled.
// After reset busy_o stays high while the cosine table is copied through the RAMs'
// single write port; configuration is taken then.
// Reset restores every configuration register and drops any item in flight.
module cosine_sum_window_applier_core import csw_pkg::*; #(
  parameter int unsigned MAX_LENGTH      = 4096,
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] sample_in_i,
  input  logic [11:0]        sample_index_i,
  output logic               done_o,
  output logic signed [15:0] windowed_sample_o,
  output logic signed [17:0] coefficient_o,
  output logic               frame_end_o,
  output logic               index_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [2:0]  window_type_q, window_type_d;
  logic [12:0] frame_length_q, frame_length_d;
  logic [31:0] phase_step_q, phase_step_d;
  logic [11:0] tukey_ramp_q, tukey_ramp_d;
  logic [31:0] tukey_step_q, tukey_step_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    window_type_d  = window_type_q;
    frame_length_d = frame_length_q;
    phase_step_d   = phase_step_q;
    tukey_ramp_d   = tukey_ramp_q;
    tukey_step_d   = tukey_step_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WINDOW_TYPE:  window_type_d  = cfg_data_i[2:0];
        REG_FRAME_LENGTH: frame_length_d = cfg_data_i[12:0];
        REG_PHASE_STEP:   phase_step_d   = cfg_data_i;
        REG_TUKEY_RAMP:   tukey_ramp_d   = cfg_data_i[11:0];
        REG_TUKEY_STEP:   tukey_step_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_type_q  <= WIN_HANN;
      frame_length_q <= 13'd1024;
      phase_step_q   <= 32'd4198463;
      tukey_ramp_q   <= 12'd128;
      tukey_step_q   <= 32'd16777216;
    end else begin
      window_type_q  <= window_type_d;
      frame_length_q <= frame_length_d;
      phase_step_q   <= phase_step_d;
      tukey_ramp_q   <= tukey_ramp_d;
      tukey_step_q   <= tukey_step_d;
    end
  end

  logic fill_done;
  logic accept;

  assign busy_o = !fill_done;
  assign accept = start_i && !busy_o;

  logic               ph_valid, lk_valid, mx_valid;
  logic signed [15:0] ph_sample, lk_sample, mx_sample;
  logic [31:0]        ph_phase;
  ctl_t               ph_ctl, lk_ctl, mx_ctl;
  logic [3:0][16:0]   lk_mag;
  logic [3:0]         lk_neg;
  logic signed [17:0] mx_coef;

  csw_phase #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .sample_i       (sample_in_i),
    .index_i        (sample_index_i),
    .window_type_i  (window_type_q),
    .frame_length_i (frame_length_q),
    .phase_step_i   (phase_step_q),
    .tukey_ramp_i   (tukey_ramp_q),
    .tukey_step_i   (tukey_step_q),
    .valid_o        (ph_valid),
    .sample_o       (ph_sample),
    .phase_o        (ph_phase),
    .ctl_o          (ph_ctl)
  );

  csw_lookup #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (ph_valid),
    .sample_i    (ph_sample),
    .phase_i     (ph_phase),
    .ctl_i       (ph_ctl),
    .fill_done_o (fill_done),
    .valid_o     (lk_valid),
    .sample_o    (lk_sample),
    .ctl_o       (lk_ctl),
    .mag_o       (lk_mag),
    .neg_o       (lk_neg)
  );

  csw_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_type_i (window_type_q),
    .valid_i       (lk_valid),
    .sample_i      (lk_sample),
    .ctl_i         (lk_ctl),
    .mag_i         (lk_mag),
    .neg_i         (lk_neg),
    .valid_o       (mx_valid),
    .sample_o      (mx_sample),
    .ctl_o         (mx_ctl),
    .coef_o        (mx_coef)
  );

  csw_apply u_apply (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (mx_valid),
    .sample_i          (mx_sample),
    .ctl_i             (mx_ctl),
    .coef_i            (mx_coef),
    .done_o            (done_o),
    .windowed_sample_o (windowed_sample_o),
    .coefficient_o     (coefficient_o),
    .frame_end_o       (frame_end_o),
    .index_error_o     (index_error_o)
  );

endmodule

### design/cosine_sum_window_applier_core_chk.sv
// Port-level checker for the window applier, bound to the top level.
`include "cosine_sum_window_applier_core_assert.svh"

module cosine_sum_window_applier_core_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [15:0] sample_in_i,
  input logic [11:0]        sample_index_i,
  input logic               done_o,
  input logic signed [15:0] windowed_sample_o,
  input logic signed [17:0] coefficient_o,
  input logic               frame_end_o,
  input logic               index_error_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [2:0]         cfg_index_i,
  input logic [31:0]        cfg_data_i
);

  localparam int unsigned Latency = 10;

  // Every accepted item gives exactly one result.
  // It is only checked when reset was already released at the start of the look-back window.
  `CSW_ASSERT_IMP(a_latency, $past(rst_ni, Latency),
                  done_o == $past(start_i && !busy_o, Latency),
                  "result strobe out of step with accepted items")

  // An out-of-frame index carries no coefficient, no sample and no frame end.
  `CSW_ASSERT_IMP(a_err_zero, done_o && index_error_o,
                  coefficient_o == '0 && windowed_sample_o == '0 && !frame_end_o,
                  "out-of-frame result is not cleared")

  // The table copy runs once after reset.
  `CSW_ASSERT_NXT(a_fill_once, !busy_o, !busy_o, "busy raised again after the table copy")

  // Nothing can come out while the table is still being copied.
  `CSW_ASSERT_IMP(a_quiet_fill, busy_o, !done_o, "result during the table copy")

endmodule

bind cosine_sum_window_applier_core cosine_sum_window_applier_core_chk u_chk (.*);
